### rtl/osme_pkg.sv
// Shared types, constants and helpers for the one-shot modifier expander.
// No dependencies; every other file in rtl/ imports this package.
package osme_pkg;

  localparam int PAIRS      = 4;
  localparam int KEY_BITS   = 16;
  localparam int KEY_W      = 16;
  localparam int MOD_W      = 8;
  localparam int MOD_IDX_W  = 3;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  // Trigger keycodes and event keycodes are compared in the low KEY_BITS bits
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
                                          KEY_W'((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [KEY_W-1:0] PLAIN_KEY_MAX = KEY_W'(8'hFF);
  localparam logic [CNT_W-1:0] PAIRS_CNT     = CNT_W'(PAIRS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_BASE  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ACT_PASS    = 3'd0,
    ACT_ABSORB  = 3'd1,
    ACT_PRESS   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_SEND    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CMD_PASS   = 2'd0,
    CMD_ABSORB = 2'd1,
    CMD_FIRE   = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MOD_PRESS,
    SEQ_KEY,
    SEQ_SEND_DOWN,
    SEQ_MOD_RELEASE,
    SEQ_SEND_UP
  } seq_state_t;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key_code;
    logic             pressed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       action;
    logic             is_modifier;
    logic [KEY_W-1:0] code;
    logic             last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic [MOD_W-1:0] mods;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [MOD_IDX_W-1:0] lowest_set(input logic [MOD_W-1:0] m);
    logic [MOD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MOD_W - 1; i >= 0; i--) begin
      if (m[i]) idx = MOD_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

### rtl/osme_front.sv
// Front end: configuration registers, pending modifier mask and classification.
// Depends on osme_pkg; feeds one command per key event into osme_cmd_fifo.
module osme_front
  import osme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  in_item_t              item,
  output logic                  cmd_push,
  output cmd_t                  cmd
);

  logic [CNT_W-1:0]      pair_count_r;
  logic [CFG_DATA_W-1:0] pair_entry_r [PAIRS];
  logic [MOD_W-1:0]      pending_r, pending_nxt;

  logic [CNT_W-1:0] count_sat;
  logic [KEY_W-1:0] key;
  logic             hit;
  logic [MOD_W-1:0] hit_mods;
  logic             fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r <= '0;
      for (int i = 0; i < PAIRS; i++) pair_entry_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PAIR_COUNT) begin
        pair_count_r <= cfg_data[CNT_W-1:0];
      end
      for (int i = 0; i < PAIRS; i++) begin
        if (cfg_index == REG_PAIR_BASE + CFG_IDX_W'(i)) pair_entry_r[i] <= cfg_data;
      end
    end
  end

  assign count_sat = (pair_count_r > PAIRS_CNT) ? PAIRS_CNT : pair_count_r;
  assign key       = item.key_code & KEY_MASK;

  // First matching pair wins
  always_comb begin
    hit      = 1'b0;
    hit_mods = '0;
    for (int i = 0; i < PAIRS; i++) begin
      if (!hit && (CNT_W'(i) < count_sat) &&
          ((pair_entry_r[i][CFG_DATA_W-1:MOD_W] & KEY_MASK) == key)) begin
        hit      = 1'b1;
        hit_mods = pair_entry_r[i][MOD_W-1:0];
      end
    end
  end

  assign fire = !hit && (pending_r != '0) && (key <= PLAIN_KEY_MAX) && item.pressed;

  always_comb begin
    pending_nxt = pending_r;
    cmd.key     = key;
    cmd.mods    = pending_r;
    cmd.kind    = CMD_PASS;
    if (hit) begin
      cmd.kind = CMD_ABSORB;
    end else if (fire) begin
      cmd.kind = CMD_FIRE;
    end
    if (accept) begin
      if (item.mode) begin
        pending_nxt = '0;
      end else if (hit && item.pressed) begin
        pending_nxt = pending_r | hit_mods;
      end else if (fire) begin
        pending_nxt = '0;
      end
    end
  end

  // Clear commands stop here
  assign cmd_push = accept && !item.mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

endmodule

### rtl/osme_cmd_fifo.sv
// Short command queue between the front end and the sequencer.
// Depends on osme_pkg for cmd_t and the queue depth.
module osme_cmd_fifo
  import osme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cmd_t       wr_data,
  input  logic       rd_en,
  output cmd_t       rd_data,
  output fifo_stat_t stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;

  assign stat.full  = (count_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (wr_en && !rd_en)      count_r <= count_r + 1'b1;
      else if (rd_en && !wr_en) count_r <= count_r - 1'b1;
    end
  end

endmodule

### rtl/osme_back.sv
// Sequencer: expands commands into results, one per cycle unless stalled.
// Depends on osme_pkg; drains osme_cmd_fifo and owns the output register.
module osme_back
  import osme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       head_valid,
  output logic       take,
  input  logic       pop,
  output logic       out_valid,
  output out_item_t  out_item
);

  seq_state_t       state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [MOD_W-1:0] mods_r, mods_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  out_item_t        out_r;
  logic             out_valid_r, out_valid_nxt;

  logic                 advance;
  logic                 emit;
  out_item_t            res;
  logic [MOD_W-1:0]     rem_low;
  logic [MOD_IDX_W-1:0] idx;

  assign advance = !out_valid_r || pop;
  assign rem_low = rem_r & (rem_r - 1'b1);
  assign idx     = lowest_set(rem_r);

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    mods_nxt  = mods_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    take      = 1'b0;
    res       = '0;
    unique case (state_r)
      SEQ_IDLE: begin
        res.code = head.key;
        if (head_valid && advance) begin
          emit = 1'b1;
          take = 1'b1;
        end
        unique case (head.kind)
          CMD_ABSORB: begin
            res.action = ACT_ABSORB;
            res.last   = 1'b1;
          end
          CMD_FIRE: begin
            res.action = ACT_ABSORB;
            if (take) begin
              state_nxt = SEQ_MOD_PRESS;
              key_nxt   = head.key;
              mods_nxt  = head.mods;
              rem_nxt   = head.mods;
            end
          end
          default: begin
            res.action = ACT_PASS;
            res.last   = 1'b1;
          end
        endcase
      end
      SEQ_MOD_PRESS: begin
        res.action      = ACT_PRESS;
        res.is_modifier = 1'b1;
        res.code        = KEY_W'(idx);
        emit            = advance;
        if (advance) begin
          rem_nxt = rem_low;
          if (rem_low == '0) state_nxt = SEQ_KEY;
        end
      end
      SEQ_KEY: begin
        res.action = ACT_PRESS;
        res.code   = key_r;
        emit       = advance;
        if (advance) state_nxt = SEQ_SEND_DOWN;
      end
      SEQ_SEND_DOWN: begin
        res.action = ACT_SEND;
        emit       = advance;
        if (advance) begin
          state_nxt = SEQ_MOD_RELEASE;
          rem_nxt   = mods_r;
        end
      end
      SEQ_MOD_RELEASE: begin
        res.action      = ACT_RELEASE;
        res.is_modifier = 1'b1;
        res.code        = KEY_W'(idx);
        emit            = advance;
        if (advance) begin
          rem_nxt = rem_low;
          if (rem_low == '0) state_nxt = SEQ_SEND_UP;
        end
      end
      SEQ_SEND_UP: begin
        res.action = ACT_SEND;
        res.last   = 1'b1;
        emit       = advance;
        if (advance) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    mods_r <= mods_nxt;
    rem_r  <= rem_nxt;
    if (emit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### rtl/one_shot_modifier_expander_top.sv
// Top level of the one-shot modifier expander: front end, command queue, sequencer.
// Depends on osme_pkg, osme_front, osme_cmd_fifo and osme_back.
//
//   channel   ports                               moves
//   input     push, full, in_item                 key event or clear command
//   result    empty, pop, out_item                one result item
//   config    cfg_valid, cfg_ready, cfg_index,    one register write
//             cfg_data
//
// One input item is accepted per cycle while the four-entry command queue has room.
// The sequencer gives one result per cycle unless the result side stalls: a pass or
// absorb yields one result, a firing key an absorb, modifier presses, the key press,
// a send, modifier releases and a send; a clear yields none. Results are registered.
// Synchronous reset clears the mask, the configuration and the queues.
// A stalled result side fills the queue, and full then holds the input side.
module one_shot_modifier_expander_top
  import osme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fifo_stat_t stat;
  cmd_t       cmd_in, cmd_head;
  logic       cmd_push, cmd_take;
  logic       accept;
  logic       out_valid;

  assign cfg_ready = 1'b1;
  assign full      = stat.full;
  assign accept    = push && !stat.full;
  assign empty     = !out_valid;

  osme_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  osme_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .rd_en  (cmd_take),
    .rd_data(cmd_head),
    .stat   (stat)
  );

  osme_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (cmd_head),
    .head_valid(!stat.empty),
    .take      (cmd_take),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A firing sequence streams without gaps once started
  a_seq_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_item.last) |=> !empty)
    else $error("result sequence broke off before its last item");

  a_mod_index: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.is_modifier) |->
      (out_item.code[KEY_W-1:MOD_IDX_W] == '0 &&
       (out_item.action == ACT_PRESS || out_item.action == ACT_RELEASE)))
    else $error("modifier result with bad index or action");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty) && !(cmd_take && stat.empty))
    else $error("command queue flags inconsistent");

endmodule
